@@ rtl/core/ssp_pkg.sv @@
// Package for the serial shift port: opcodes, mode and clock source codes,
// and the request and response item structs.
// No dependencies.
package ssp_pkg;

   typedef enum logic [2:0] {
      OP_PIN    = 3'd0,
      OP_TICK   = 3'd1,
      OP_CTRL   = 3'd2,
      OP_STATUS = 3'd3,
      OP_DATA   = 3'd4
   } opcode_type;

   // wire modes: two-wire is any code with the upper bit set
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_THREE = 2'd1;

   // clock sources: external edge is any code with the upper bit set
   localparam logic [1:0] SRC_STROBE = 2'd0;
   localparam logic [1:0] SRC_TIMER  = 2'd1;

   localparam int SHIFT_W = 8;
   localparam int COUNT_W = 4;

   typedef struct packed {
      logic [2:0]         opcode;
      logic               ck_level;
      logic               di_level;
      logic [1:0]         wire_mode;
      logic [1:0]         clock_select;
      logic               clk_strobe;
      logic               toggle_strobe;
      logic [COUNT_W-1:0] count_value;
      logic               stop_clear;
      logic [SHIFT_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift_value;
      logic [SHIFT_W-1:0] buffer_value;
      logic [COUNT_W-1:0] count_now;
      logic               stop_seen;
      logic               start_pulse;
      logic               overflow_pulse;
      logic               data_out_pin;
      logic               sda_port_bit;
      logic               clock_port_bit;
   } rsp_type;

endpackage

@@ rtl/core/serial_shift_port_with_counter.sv @@
// Serial shift port with bit counter: top level.
// Holds the item register, the port state and the response register.
// Depends on ssp_pkg.
//
// Usage: every request item is a pin sample, a timer tick or a control,
// status or data register write (opcode). Each item returns exactly one
// response item with the shift, buffer and counter contents, the stop flag,
// start and overflow pulses, and the data, sda and clock port bits.
// An item accepted on req_ waits in the item register; when it fires, it
// is applied to the port state and loads the response register, from which
// the response is offered on rsp_.
// Throughput is one item per cycle unless rsp_stall holds: the state update
// is a single short pass from the item register to the response register.
// When rsp_stall holds a waiting response, one more item is taken into the
// item register; req_stall rises only when both registers are full.
// Reset (synchronous, active high) clears the shift, buffer and counter
// registers, the mode (off), the clock source (strobe), all latches and
// flags, and empties both registers; held items are dropped, none invented.
module serial_shift_port_with_counter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssp_pkg::rsp_type rsp_data
);
   import ssp_pkg::*;

   // pipeline registers
   logic    item_valid_ff;
   req_type item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic    out_load;
   logic    fire;

   // port state
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [SHIFT_W-1:0] buffer_ff, buffer_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         mode_ff, mode_in;
   logic [1:0]         source_ff, source_in;
   logic               strobe_ff, strobe_in;
   logic               stop_ff, stop_in;
   logic               last_ck_ff, last_ck_in;
   logic               last_di_ff, last_di_in;
   logic               pending_ff, pending_in;
   logic               out_pin_ff, out_pin_in;
   logic               sda_ff, sda_in;
   logic               clk_bit_ff, clk_bit_in;
   logic               start_now;
   logic               ovf_now;

   // clock levels seen through the selected polarity
   logic old_ck;
   logic new_ck;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && out_load;
   assign req_stall = item_valid_ff && !out_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign old_ck = last_ck_ff ^ source_ff[0];
   assign new_ck = item_ff.ck_level ^ source_ff[0];

   always_comb begin
      shift_in   = shift_ff;
      buffer_in  = buffer_ff;
      count_in   = count_ff;
      mode_in    = mode_ff;
      source_in  = source_ff;
      strobe_in  = strobe_ff;
      stop_in    = stop_ff;
      last_ck_in = last_ck_ff;
      last_di_in = last_di_ff;
      pending_in = pending_ff;
      out_pin_in = out_pin_ff;
      sda_in     = sda_ff;
      clk_bit_in = clk_bit_ff;
      start_now  = 1'b0;
      ovf_now    = 1'b0;

      case (item_ff.opcode)
         OP_PIN: begin
            // start and stop conditions while the clock line is high
            if (mode_ff[1] && item_ff.ck_level) begin
               if (last_di_ff && !item_ff.di_level) begin
                  start_now = 1'b1;
               end else if (!last_di_ff && item_ff.di_level) begin
                  stop_in = 1'b1;
               end
            end
            last_di_in = item_ff.di_level;
            if (last_ck_ff != item_ff.ck_level) begin
               if (source_ff[1]) begin
                  if (!strobe_ff) begin
                     count_in = count_ff + COUNT_W'(1);
                     if (count_in == '0) begin
                        buffer_in = shift_ff;
                        ovf_now   = 1'b1;
                     end
                  end
                  if (!old_ck && new_ck) begin
                     pending_in = shift_ff[SHIFT_W-2];
                     shift_in   = {shift_ff[SHIFT_W-2:0], item_ff.di_level};
                  end else if (old_ck && !new_ck) begin
                     if (mode_ff == MODE_THREE) begin
                        out_pin_in = pending_ff;
                     end else if (mode_ff[1]) begin
                        sda_in = pending_ff;
                     end
                  end
               end
               last_ck_in = item_ff.ck_level;
            end
         end
         OP_TICK: begin
            if (source_ff == SRC_TIMER) begin
               pending_in = shift_ff[SHIFT_W-2];
               shift_in   = {shift_ff[SHIFT_W-2:0], last_di_ff};
               count_in   = count_ff + COUNT_W'(1);
               // the tick shifts first, so the buffer takes the new byte
               if (count_in == '0) begin
                  buffer_in = shift_in;
                  ovf_now   = 1'b1;
               end
               if (mode_ff == MODE_THREE) begin
                  out_pin_in = pending_in;
               end else if (mode_ff[1]) begin
                  sda_in = pending_in;
               end
            end
         end
         OP_CTRL: begin
            mode_in   = item_ff.wire_mode;
            source_in = item_ff.clock_select;
            if (item_ff.wire_mode != MODE_OFF) begin
               if (item_ff.toggle_strobe) begin
                  clk_bit_in = !clk_bit_ff;
               end
               strobe_in = item_ff.clk_strobe;
               if (item_ff.clock_select[1]) begin
                  if (item_ff.clk_strobe && item_ff.toggle_strobe) begin
                     count_in = count_ff + COUNT_W'(1);
                     if (count_in == '0) begin
                        buffer_in = shift_ff;
                        ovf_now   = 1'b1;
                     end
                  end
               end else if (item_ff.clock_select == SRC_STROBE) begin
                  if (item_ff.clk_strobe) begin
                     // count before shift: buffer takes the old byte
                     count_in = count_ff + COUNT_W'(1);
                     if (count_in == '0) begin
                        buffer_in = shift_ff;
                        ovf_now   = 1'b1;
                     end
                     pending_in = shift_ff[SHIFT_W-2];
                     shift_in   = {shift_ff[SHIFT_W-2:0], last_di_ff};
                  end else if (item_ff.wire_mode == MODE_THREE) begin
                     out_pin_in = pending_ff;
                  end else if (item_ff.wire_mode[1]) begin
                     sda_in = pending_ff;
                  end
               end
            end
         end
         OP_STATUS: begin
            count_in = item_ff.count_value;
            if (item_ff.stop_clear) begin
               stop_in = 1'b0;
            end
         end
         OP_DATA: begin
            shift_in   = item_ff.data_byte;
            pending_in = item_ff.data_byte[SHIFT_W-1];
            if (mode_ff == MODE_THREE) begin
               out_pin_in = item_ff.data_byte[SHIFT_W-1];
            end else if (mode_ff[1]) begin
               sda_in = item_ff.data_byte[SHIFT_W-1];
            end
         end
         default: begin
         end
      endcase

      rsp_in.shift_value    = shift_in;
      rsp_in.buffer_value   = buffer_in;
      rsp_in.count_now      = count_in;
      rsp_in.stop_seen      = stop_in;
      rsp_in.start_pulse    = start_now;
      rsp_in.overflow_pulse = ovf_now;
      rsp_in.data_out_pin   = out_pin_in;
      rsp_in.sda_port_bit   = sda_in;
      rsp_in.clock_port_bit = clk_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         shift_ff      <= '0;
         buffer_ff     <= '0;
         count_ff      <= '0;
         mode_ff       <= MODE_OFF;
         source_ff     <= SRC_STROBE;
         strobe_ff     <= 1'b0;
         stop_ff       <= 1'b0;
         last_ck_ff    <= 1'b0;
         last_di_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         out_pin_ff    <= 1'b0;
         sda_ff        <= 1'b0;
         clk_bit_ff    <= 1'b0;
      end else begin
         if (!req_stall) begin
            item_valid_ff <= req_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= item_valid_ff;
         end
         if (fire) begin
            shift_ff   <= shift_in;
            buffer_ff  <= buffer_in;
            count_ff   <= count_in;
            mode_ff    <= mode_in;
            source_ff  <= source_in;
            strobe_ff  <= strobe_in;
            stop_ff    <= stop_in;
            last_ck_ff <= last_ck_in;
            last_di_ff <= last_di_in;
            pending_ff <= pending_in;
            out_pin_ff <= out_pin_in;
            sda_ff     <= sda_in;
            clk_bit_ff <= clk_bit_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // an overflow always leaves the counter at zero
   a_ovf_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow_pulse |-> rsp_ff.count_now == '0)
      else $error("overflow reported with nonzero counter");

   // a start condition is only seen in two-wire mode
   a_start_two_wire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_pulse |-> mode_ff[1])
      else $error("start pulse outside two-wire mode");

   // a held response freezes the port state
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(shift_ff) && $stable(count_ff)
         && $stable(buffer_ff))
      else $error("port state moved while response stalled");

   // the response register reflects the state it was loaded with
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.shift_value == shift_ff && rsp_ff.count_now == count_ff
         && rsp_ff.stop_seen == stop_ff)
      else $error("response out of step with port state");

endmodule
